// ===== rtl/lcdws_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types, microcode word layout and the microcode program for the
// character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] value;
    logic       row;
    logic [5:0] column;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic [7:0] bus_data;
    logic [5:0] hold_ms;
    logic       last;
  } phase_t;

  localparam int PC_W = 6;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_CMD    = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_CURSOR = 2'd3
  } mode_t;

  // Where the pin byte comes from
  typedef enum logic {
    SRC_CONST = 1'b0,
    SRC_REQ   = 1'b1
  } src_t;

  // Which part of the request byte goes on the pins
  typedef enum logic [1:0] {
    NIB_FULL = 2'd0,
    NIB_HI   = 2'd1,
    NIB_LO   = 2'd2
  } nib_t;

  typedef struct packed {
    logic       enable;
    src_t       src;
    nib_t       nib;
    logic [7:0] data;
    logic [5:0] hold;
    logic       last;
  } ucode_t;

  typedef struct packed {
    logic   fire;    // current step emits a phase this cycle
    logic   accept;  // new request transaction taken this cycle
    ucode_t word;
  } ctl_t;

  // Program entry points
  localparam logic [PC_W-1:0] PC_INIT8 = 6'd0;
  localparam logic [PC_W-1:0] PC_INIT4 = 6'd9;
  localparam logic [PC_W-1:0] PC_BYTE8 = 6'd31;
  localparam logic [PC_W-1:0] PC_BYTE4 = 6'd33;

  function automatic ucode_t uc(logic en, src_t src, nib_t nib, logic [7:0] data,
                                logic [5:0] hold, logic last);
    ucode_t w;
    w.enable = en;
    w.src    = src;
    w.nib    = nib;
    w.data   = data;
    w.hold   = hold;
    w.last   = last;
    return w;
  endfunction

  // Constant pin byte phase
  function automatic ucode_t ucc(logic en, logic [7:0] data, logic [5:0] hold,
                                 logic last);
    return uc(en, SRC_CONST, NIB_FULL, data, hold, last);
  endfunction

  // Request byte phase
  function automatic ucode_t ucr(logic en, nib_t nib, logic [5:0] hold, logic last);
    return uc(en, SRC_REQ, nib, 8'h00, hold, last);
  endfunction

  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      // init, 8-bit bus
      6'd0:  w = ucc(1'b0, 8'h00, 6'd40, 1'b0);
      6'd1:  w = ucc(1'b1, 8'h38, 6'd2,  1'b0);
      6'd2:  w = ucc(1'b0, 8'h38, 6'd0,  1'b0);
      6'd3:  w = ucc(1'b1, 8'h0C, 6'd2,  1'b0);
      6'd4:  w = ucc(1'b0, 8'h0C, 6'd0,  1'b0);
      6'd5:  w = ucc(1'b1, 8'h01, 6'd2,  1'b0);
      6'd6:  w = ucc(1'b0, 8'h01, 6'd2,  1'b0);
      6'd7:  w = ucc(1'b1, 8'h06, 6'd2,  1'b0);
      6'd8:  w = ucc(1'b0, 8'h06, 6'd2,  1'b1);
      // init, 4-bit bus
      6'd9:  w = ucc(1'b0, 8'h00, 6'd2,  1'b0);
      6'd10: w = ucc(1'b0, 8'h00, 6'd50, 1'b0);
      6'd11: w = ucc(1'b1, 8'h30, 6'd1,  1'b0);
      6'd12: w = ucc(1'b0, 8'h30, 6'd0,  1'b0);
      6'd13: w = ucc(1'b1, 8'h30, 6'd1,  1'b0);
      6'd14: w = ucc(1'b0, 8'h30, 6'd0,  1'b0);
      6'd15: w = ucc(1'b1, 8'h30, 6'd1,  1'b0);
      6'd16: w = ucc(1'b0, 8'h30, 6'd0,  1'b0);
      6'd17: w = ucc(1'b1, 8'h20, 6'd1,  1'b0);
      6'd18: w = ucc(1'b0, 8'h20, 6'd0,  1'b0);
      6'd19: w = ucc(1'b1, 8'h20, 6'd1,  1'b0);
      6'd20: w = ucc(1'b0, 8'h20, 6'd0,  1'b0);
      6'd21: w = ucc(1'b1, 8'h80, 6'd1,  1'b0);
      6'd22: w = ucc(1'b0, 8'h80, 6'd0,  1'b0);
      6'd23: w = ucc(1'b1, 8'h00, 6'd1,  1'b0);
      6'd24: w = ucc(1'b0, 8'h00, 6'd0,  1'b0);
      6'd25: w = ucc(1'b1, 8'hC0, 6'd1,  1'b0);
      6'd26: w = ucc(1'b0, 8'hC0, 6'd0,  1'b0);
      6'd27: w = ucc(1'b1, 8'h00, 6'd1,  1'b0);
      6'd28: w = ucc(1'b0, 8'h00, 6'd0,  1'b0);
      6'd29: w = ucc(1'b1, 8'h10, 6'd1,  1'b0);
      6'd30: w = ucc(1'b0, 8'h10, 6'd2,  1'b1);
      // byte write, 8-bit bus
      6'd31: w = ucr(1'b1, NIB_FULL, 6'd2, 1'b0);
      6'd32: w = ucr(1'b0, NIB_FULL, 6'd0, 1'b1);
      // byte write, 4-bit bus
      6'd33: w = ucr(1'b1, NIB_HI, 6'd1, 1'b0);
      6'd34: w = ucr(1'b0, NIB_HI, 6'd0, 1'b0);
      6'd35: w = ucr(1'b1, NIB_LO, 6'd1, 1'b0);
      6'd36: w = ucr(1'b0, NIB_LO, 6'd0, 1'b1);
      default: w = ucc(1'b0, 8'h00, 6'd0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/char_lcd_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Character LCD write sequencer: turns requests into timed bus phases.
// ----------------------------------------------------------------------------
// Each request transaction (init, command, data or cursor set) becomes a list
// of bus phases (RS, RW, E, data pins, hold in ms), one phase per clock while
// the output side takes them. A microcode step counter emits one phase per
// cycle while the output is free, so a byte write is 2 phases on the 8-bit
// bus and 4 on the 4-bit bus; init is 9 or 22. The next request is taken in
// the cycle its predecessor's final phase is issued. The bus width register is
// written from cfg_wdata when cfg_we is high (1 selects the 4-bit bus) and is
// read when a request is taken.
module char_lcd_write_sequencer_top
  import lcdws_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  logic   cfg_wdata,
  input  logic   in_valid,
  output logic   in_stall,
  input  req_t   in_data,
  output logic   out_valid,
  input  logic   out_stall,
  output phase_t out_data
);

  ctl_t ctl;
  logic out_free;

  lcdws_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  lcdws_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctl       (ctl),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/lcdws_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcdws_sequencer
// Step counter over the microcode program: dispatches on request mode and bus
// width, steps one control word per emitted phase, stops on the last flag.
// ----------------------------------------------------------------------------
module lcdws_sequencer
  import lcdws_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  input  logic  in_valid,
  output logic  in_stall,
  input  req_t  in_data,
  input  logic  out_free,
  output ctl_t  ctl
);

  logic            busy;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            bus_width_mode;
  logic            fire;
  logic            accept;
  ucode_t          word;

  assign word     = ucode_rom(pc);
  assign fire     = busy & out_free;
  // next request may enter as the final phase leaves
  assign in_stall = busy & ~(fire & word.last);
  assign accept   = in_valid & ~in_stall;

  // mode dispatch: init programs vs. shared byte-write program
  always_comb begin
    if (in_data.mode == MODE_INIT) begin
      pc_next = bus_width_mode ? PC_INIT4 : PC_INIT8;
    end else begin
      pc_next = bus_width_mode ? PC_BYTE4 : PC_BYTE8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      pc             <= '0;
      bus_width_mode <= 1'b0;
    end else begin
      if (cfg_we) begin
        bus_width_mode <= cfg_wdata;
      end
      if (accept) begin
        busy <= 1'b1;
        pc   <= pc_next;
      end else if (fire) begin
        if (word.last) begin
          busy <= 1'b0;
        end else begin
          pc <= pc + PC_W'(1);
        end
      end
    end
  end

  assign ctl.fire   = fire;
  assign ctl.accept = accept;
  assign ctl.word   = word;

endmodule

// ===== rtl/lcdws_datapath.sv =====
// ----------------------------------------------------------------------------
// lcdws_datapath
// Holds the request byte and RS level, builds each bus phase from the current
// control word and keeps it in the output register.
// ----------------------------------------------------------------------------
module lcdws_datapath
  import lcdws_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  req_t   in_data,
  input  ctl_t   ctl,
  output logic   out_free,
  output logic   out_valid,
  input  logic   out_stall,
  output phase_t out_data
);

  logic [7:0] req_byte;
  logic [7:0] req_byte_next;
  logic       req_rs;
  logic [7:0] pins;
  phase_t     phase;

  // cursor command: 0x80 | row << 6 | column
  always_comb begin
    case (in_data.mode)
      MODE_CURSOR: req_byte_next = {1'b1, in_data.row, in_data.column};
      default:     req_byte_next = in_data.value;
    endcase
  end

  always_comb begin
    if (ctl.word.src == SRC_CONST) begin
      pins = ctl.word.data;
    end else begin
      case (ctl.word.nib)
        NIB_HI:  pins = {req_byte[7:4], 4'h0};
        NIB_LO:  pins = {req_byte[3:0], 4'h0};
        default: pins = req_byte;
      endcase
    end
  end

  always_comb begin
    phase.reg_select = (ctl.word.src == SRC_REQ) & req_rs;
    phase.read_write = 1'b0;
    phase.enable     = ctl.word.enable;
    phase.bus_data   = pins;
    phase.hold_ms    = ctl.word.hold;
    phase.last       = ctl.word.last;
  end

  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= ctl.fire;
    end
    if (out_free & ctl.fire) begin
      out_data <= phase;
    end
    if (ctl.accept) begin
      req_byte <= req_byte_next;
      req_rs   <= (in_data.mode == MODE_DATA);
    end
  end

endmodule

// ===== dv/tb_char_lcd_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_char_lcd_write_sequencer_top
// Self-checking bench for the character LCD write sequencer. Requests (init,
// command, data, cursor set) are driven on both bus widths. Directed cases
// come first, then a backpressure case, then random traffic. Sender gaps and
// receiver stalls are random. Each phase is checked against a local
// phase-list predictor.
// ----------------------------------------------------------------------------
module tb_char_lcd_write_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdws_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_we = 1'b0;
  logic   cfg_wdata = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  req_t   in_data = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  phase_t out_data;

  // predictor state
  bit     bus_four_bit = 1'b0;
  phase_t expected_phases[$];
  phase_t req_phases[$];

  int err_count = 0;
  int cycle_count = 0;

  // sender / receiver knobs
  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_trigger = 0;

  char_lcd_write_sequencer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // ---------------- phase-list predictor ----------------
  function automatic void add_phase(bit rs, bit e, logic [7:0] pins, logic [5:0] hold);
    phase_t p;
    p.reg_select = rs;
    p.read_write = 1'b0;
    p.enable     = e;
    p.bus_data   = pins;
    p.hold_ms    = hold;
    p.last       = 1'b0;
    req_phases.push_back(p);
  endfunction

  // one byte: single strobe on the 8-bit bus, two nibble strobes on the 4-bit bus
  function automatic void add_byte(bit rs, logic [7:0] b, logic [5:0] tail_hold);
    if (!bus_four_bit) begin
      add_phase(rs, 1'b1, b, 6'd2);
      add_phase(rs, 1'b0, b, tail_hold);
    end else begin
      add_phase(rs, 1'b1, {b[7:4], 4'h0}, 6'd1);
      add_phase(rs, 1'b0, {b[7:4], 4'h0}, 6'd0);
      add_phase(rs, 1'b1, {b[3:0], 4'h0}, 6'd1);
      add_phase(rs, 1'b0, {b[3:0], 4'h0}, tail_hold);
    end
  endfunction

  function automatic void predict_phases(req_t r);
    phase_t p;
    req_phases.delete();
    case (mode_t'(r.mode))
      MODE_INIT: begin
        if (!bus_four_bit) begin
          add_phase(1'b0, 1'b0, 8'h00, 6'd40);
          add_byte(1'b0, 8'h38, 6'd0);
          add_byte(1'b0, 8'h0C, 6'd0);
          add_byte(1'b0, 8'h01, 6'd2);
          add_byte(1'b0, 8'h06, 6'd2);
        end else begin
          add_phase(1'b0, 1'b0, 8'h00, 6'd2);
          add_phase(1'b0, 1'b0, 8'h00, 6'd50);
          add_byte(1'b0, 8'h33, 6'd0);
          add_byte(1'b0, 8'h32, 6'd0);
          add_byte(1'b0, 8'h28, 6'd0);
          add_byte(1'b0, 8'h0C, 6'd0);
          add_byte(1'b0, 8'h01, 6'd2);
        end
      end
      MODE_CMD:  add_byte(1'b0, r.value, 6'd0);
      MODE_DATA: add_byte(1'b1, r.value, 6'd0);
      default:   add_byte(1'b0, 8'h80 + {2'b00, r.column} + (r.row ? 8'h40 : 8'h00), 6'd0);
    endcase
    p = req_phases[req_phases.size() - 1];
    p.last = 1'b1;
    req_phases[req_phases.size() - 1] = p;
    foreach (req_phases[i]) expected_phases.push_back(req_phases[i]);
  endfunction

  // ---------------- checker ----------------
  always @(posedge clk) begin : check_phases
    phase_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_phases.size() == 0) begin
        report_mismatch($sformatf("phase with nothing expected: %h", out_data));
      end else begin
        want = expected_phases.pop_front();
        if (out_data.reg_select !== want.reg_select)
          report_mismatch($sformatf("reg_select exp %b got %b", want.reg_select,
                                    out_data.reg_select));
        if (out_data.read_write !== want.read_write)
          report_mismatch($sformatf("read_write exp %b got %b", want.read_write,
                                    out_data.read_write));
        if (out_data.enable !== want.enable)
          report_mismatch($sformatf("enable exp %b got %b", want.enable, out_data.enable));
        if (out_data.bus_data !== want.bus_data)
          report_mismatch($sformatf("bus_data exp %h got %h", want.bus_data,
                                    out_data.bus_data));
        if (out_data.hold_ms !== want.hold_ms)
          report_mismatch($sformatf("hold_ms exp %0d got %0d", want.hold_ms,
                                    out_data.hold_ms));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last exp %b got %b", want.last, out_data.last));
      end
    end
  end

  // ---------------- receiver stall pattern ----------------
  always @(negedge clk) begin : phase_sink
    int hold_left;
    int hold_taken;
    if (hold_trigger != hold_taken) begin
      hold_taken = hold_trigger;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------- sender ----------------
  function automatic req_t make_req(mode_t m, logic [7:0] v, bit row, logic [5:0] col);
    req_t r;
    r.mode   = m;
    r.value  = v;
    r.row    = row;
    r.column = col;
    return r;
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.mode   = (pick < 4) ? MODE_INIT : (pick < 36) ? MODE_CMD :
               (pick < 68) ? MODE_DATA : MODE_CURSOR;
    r.value  = 8'($urandom);
    r.row    = 1'($urandom);
    r.column = 6'($urandom);
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_data  <= rand_request();
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    // expectations go in before the transaction can be taken
    predict_phases(r);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_phases.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bus_width(input bit four);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= four;
    @(negedge clk);
    cfg_we <= 1'b0;   // cfg_wdata stays at the written level
    bus_four_bit = four;
  endtask

  // ---------------- tests ----------------
  task automatic test_directed_8bit();
    stall_pct = 0;
    gap_max   = 0;
    set_bus_width(1'b0);
    send_request(make_req(MODE_INIT, 8'h00, 1'b0, 6'd0));
    send_request(make_req(MODE_CMD, 8'h00, 1'b0, 6'd0));
    send_request(make_req(MODE_CMD, 8'hFF, 1'b1, 6'd63));
    send_request(make_req(MODE_DATA, 8'h00, 1'b0, 6'd0));
    send_request(make_req(MODE_DATA, 8'hFF, 1'b0, 6'd0));
    send_request(make_req(MODE_DATA, 8'h5A, 1'b0, 6'd0));
    send_request(make_req(MODE_CURSOR, 8'h00, 1'b0, 6'd0));
    send_request(make_req(MODE_CURSOR, 8'hFF, 1'b1, 6'd63));
    send_request(make_req(MODE_CURSOR, 8'h00, 1'b0, 6'd63));
    send_request(make_req(MODE_CURSOR, 8'h00, 1'b1, 6'd0));
    wait_idle();
  endtask

  task automatic test_directed_4bit();
    stall_pct = 25;
    gap_max   = 2;
    set_bus_width(1'b1);
    send_request(make_req(MODE_INIT, 8'h00, 1'b0, 6'd0));
    send_request(make_req(MODE_CMD, 8'hA5, 1'b0, 6'd0));
    send_request(make_req(MODE_CMD, 8'h00, 1'b0, 6'd0));
    send_request(make_req(MODE_DATA, 8'hFF, 1'b0, 6'd0));
    send_request(make_req(MODE_DATA, 8'h0F, 1'b0, 6'd0));
    send_request(make_req(MODE_CURSOR, 8'h00, 1'b1, 6'd63));
    send_request(make_req(MODE_CURSOR, 8'h00, 1'b0, 6'd21));
    wait_idle();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    stall_pct = 0;
    gap_max   = 0;
    @(posedge clk);
    hold_len = 150;
    hold_trigger++;
    repeat (24) send_request(rand_request());
    wait_idle();
  endtask

  task automatic test_random();
    int pcts[3] = '{0, 30, 70};
    int gaps[3] = '{0, 3, 10};
    for (int blk = 0; blk < 8; blk++) begin
      set_bus_width(blk[0] ^ ($urandom_range(0, 3) == 0));
      stall_pct = pcts[$urandom_range(0, 2)];
      gap_max   = gaps[$urandom_range(0, 2)];
      repeat (35) send_request(rand_request());
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_8bit();
    test_directed_4bit();
    test_backpressure();
    test_random();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_phases.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
